// ===== rtl/avdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Averaged IR distance converter package
// Widths, register indexes, reset values and status codes shared by the
// converter RTL.
// ----------------------------------------------------------------------------
package avdc_pkg;

  localparam int SAMPLE_BITS = 10;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Register widths
  localparam int COUNT_W = 8;
  localparam int ADC_W   = 10;
  localparam int DLIM_W  = 16;
  localparam int NUM_W   = 16;

  // Datapath widths
  localparam int SUM_W    = SAMPLE_BITS + COUNT_W;
  localparam int DVS_W    = (SAMPLE_BITS > ADC_W) ? SAMPLE_BITS : ADC_W;
  localparam int DVD_W    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int CNT_W    = $clog2(DVD_W);
  localparam int DIST_W   = 17;
  localparam int STATUS_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W  = STATUS_W + DIST_W + SAMPLE_BITS;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd6;

  // Reset values
  localparam logic [COUNT_W-1:0] RST_SAMPLES   = 8'd16;
  localparam logic [ADC_W-1:0]   RST_ADC_LOW   = 10'd60;
  localparam logic [ADC_W-1:0]   RST_ADC_HIGH  = 10'd900;
  localparam logic [DLIM_W-1:0]  RST_DIST_LOW  = 16'd20;
  localparam logic [DLIM_W-1:0]  RST_DIST_HIGH = 16'd80;
  localparam logic [NUM_W-1:0]   RST_NUMERATOR = 16'd4800;
  localparam logic [ADC_W-1:0]   RST_OFFSET    = 10'd20;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/averaged_ir_distance_converter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Averaged IR distance converter
// Averages a configured number of converter samples and turns the mean into
// a distance reading through an inverse curve, with window checks.
// ----------------------------------------------------------------------------
// A sample that does not close a reading is taken in the idle state, and the next
// sample may follow at once. The sample that closes a reading holds off input
// while one shared restoring divider, one quotient bit per cycle over an
// 18-bit shift register, first divides the sum by the sample count and then
// the curve numerator by (mean - offset), with in_tready low throughout; the
// distance division is skipped when the mean is outside the valid window or
// at or below the offset, and both are skipped when the sample count is zero.
// The done state also waits while a previous reading still sits in the output
// register. Readings carry status 0 ok, 1 mean outside the valid window,
// 2 distance out of range; distance is -1 when the mean is at or below the
// offset and 0 when the mean is invalid.
module averaged_ir_distance_converter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [avdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [avdc_pkg::CFG_W-1:0]        cfg_wdata,
  // samples
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [avdc_pkg::IN_DATA_W-1:0]    in_tdata,   // sample
  // readings
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [avdc_pkg::OUT_DATA_W-1:0]        out_tdata   // status, distance, mean_sample
);
  import avdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_MEAN,
    S_EVAL,
    S_DIV_DIST,
    S_DONE
  } state_t;

  // configuration registers
  logic [COUNT_W-1:0] spr_r;
  logic [ADC_W-1:0]   adc_low_r;
  logic [ADC_W-1:0]   adc_high_r;
  logic [DLIM_W-1:0]  dist_low_r;
  logic [DLIM_W-1:0]  dist_high_r;
  logic [NUM_W-1:0]   numerator_r;
  logic [ADC_W-1:0]   offset_r;

  state_t                  state_r;
  logic [SUM_W-1:0]        sum_r;
  logic [COUNT_W-1:0]      taken_r;
  logic [DVS_W-1:0]        rem_r;
  logic [DVD_W-1:0]        quo_r;
  logic [DVS_W-1:0]        dvs_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [SAMPLE_BITS-1:0]  mean_r;
  logic signed [DIST_W-1:0] dist_r;
  logic                    invalid_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  logic                    in_acc;
  logic [SUM_W-1:0]        sum_nxt;
  logic [COUNT_W-1:0]      taken_nxt;
  logic                    close_rd;
  logic [DVS_W:0]          trial;
  logic                    fits;
  logic [DVS_W-1:0]        rem_nxt;
  logic [DVD_W-1:0]        quo_nxt;
  logic [DVS_W-1:0]        mean_ext;
  logic                    mean_bad;
  logic                    mean_low;
  logic                    out_free;
  status_t                 status;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign sum_nxt   = sum_r + SUM_W'(in_tdata[SAMPLE_BITS-1:0]);
  assign taken_nxt = taken_r + COUNT_W'(1);
  assign close_rd  = (taken_nxt == '0) || (taken_nxt >= spr_r);

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  assign trial   = {rem_r, quo_r[DVD_W-1]};
  assign fits    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
  assign quo_nxt = {quo_r[DVD_W-2:0], fits};

  assign mean_ext = DVS_W'(mean_r);
  assign mean_bad = (mean_ext < DVS_W'(adc_low_r)) || (mean_ext > DVS_W'(adc_high_r));
  assign mean_low = (mean_ext <= DVS_W'(offset_r));

  always_comb begin
    priority if (invalid_r) begin
      status = STATUS_INVALID;
    end else if (dist_r[DIST_W-1] || (dist_r[DLIM_W-1:0] < dist_low_r)
                 || (dist_r[DLIM_W-1:0] > dist_high_r)) begin
      status = STATUS_RANGE;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r       <= RST_SAMPLES;
      adc_low_r   <= RST_ADC_LOW;
      adc_high_r  <= RST_ADC_HIGH;
      dist_low_r  <= RST_DIST_LOW;
      dist_high_r <= RST_DIST_HIGH;
      numerator_r <= RST_NUMERATOR;
      offset_r    <= RST_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLES:   spr_r       <= cfg_wdata[COUNT_W-1:0];
        REG_ADC_LOW:   adc_low_r   <= cfg_wdata[ADC_W-1:0];
        REG_ADC_HIGH:  adc_high_r  <= cfg_wdata[ADC_W-1:0];
        REG_DIST_LOW:  dist_low_r  <= cfg_wdata[DLIM_W-1:0];
        REG_DIST_HIGH: dist_high_r <= cfg_wdata[DLIM_W-1:0];
        REG_NUMERATOR: numerator_r <= cfg_wdata[NUM_W-1:0];
        REG_OFFSET:    offset_r    <= cfg_wdata[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sum_r        <= '0;
      taken_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            invalid_r <= 1'b0;
            dist_r    <= '0;
            if (spr_r == '0 || (close_rd && taken_nxt == '0)) begin
              // zero count: reading with mean 0, sample dropped
              sum_r   <= '0;
              taken_r <= '0;
              mean_r  <= '0;
              state_r <= S_EVAL;
            end else if (close_rd) begin
              sum_r   <= '0;
              taken_r <= '0;
              quo_r   <= DVD_W'(sum_nxt);
              dvs_r   <= DVS_W'(taken_nxt);
              rem_r   <= '0;
              cnt_r   <= CNT_W'(DVD_W - 1);
              state_r <= S_DIV_MEAN;
            end else begin
              sum_r   <= sum_nxt;
              taken_r <= taken_nxt;
            end
          end
        end
        S_DIV_MEAN: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            mean_r  <= quo_nxt[SAMPLE_BITS-1:0];
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          priority if (mean_bad) begin
            invalid_r <= 1'b1;
            dist_r    <= '0;
            state_r   <= S_DONE;
          end else if (mean_low) begin
            dist_r  <= '1;
            state_r <= S_DONE;
          end else begin
            quo_r   <= DVD_W'(numerator_r);
            dvs_r   <= mean_ext - DVS_W'(offset_r);
            rem_r   <= '0;
            cnt_r   <= CNT_W'(DVD_W - 1);
            state_r <= S_DIV_DIST;
          end
        end
        S_DIV_DIST: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            dist_r  <= {1'b0, quo_nxt[DLIM_W-1:0]};
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= OUT_DATA_W'({mean_r, dist_r, status});
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_MEAN || state_r == S_DIV_DIST) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_MEAN || state_r == S_DIV_DIST) |-> (dvs_r != '0))
    else $error("division started with zero divisor");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r != '1)
    else $error("sample count reached its limit without closing a reading");

  a_invalid_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[STATUS_W-1:0] == STATUS_INVALID)
      |-> (out_tdata[STATUS_W+DIST_W-1:STATUS_W] == '0))
    else $error("invalid reading carries a nonzero distance");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_DONE)
    else $error("reading presented outside the done state");
`endif

endmodule
`default_nettype wire
